// File: src/ghist_pkg.sv
// Shared widths, limits and control types for the grey histogram block.
package ghist_pkg;

  localparam int PIX_W   = 8;
  localparam int CNT_W   = 17;
  localparam int SCALE_W = 9;

  localparam int BINS_DEF = 256;

  localparam int unsigned MAX_FRAME_PIXELS = 65536;
  localparam int unsigned COUNT_CEIL       = 131071;
  localparam int unsigned COUNT_LIMIT =
    (MAX_FRAME_PIXELS > COUNT_CEIL) ? COUNT_CEIL : MAX_FRAME_PIXELS;

  localparam logic [CNT_W-1:0] COUNT_LIMIT_V = CNT_W'(COUNT_LIMIT);

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic clear;
    logic wr_en;
  } mem_ctl_t;

endpackage

// File: src/grey_histogram_with_peak_scale.sv
// Grey histogram with peak tracking and peak-relative scaling (top level).
// Read word: RAM read in S_LOOK; with peak nonzero, nine bit-serial divider steps and
//   the done flag in S_DIV; then output load in S_OUT. Accumulate writes its bin in S_LOOK.
// Flow: one word at a time (in_ready only in S_IDLE); a read word can also stall
//   in S_OUT under output back-pressure.
// Reset: synchronous, clears bin valid bits, the peak, control and output valid.
module grey_histogram_with_peak_scale #(
  parameter int BINS = ghist_pkg::BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [ghist_pkg::PIX_W-1:0]   pixel,
  input  logic                          frame_start,
  input  logic [ghist_pkg::PIX_W-1:0]   bin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ghist_pkg::CNT_W-1:0]   count,
  output logic [ghist_pkg::CNT_W-1:0]   peak,
  output logic [ghist_pkg::SCALE_W-1:0] scaled
);
  import ghist_pkg::*;

  // Frame start clears all bins at once through the valid bits; no sweep.
  localparam int AW = $clog2(BINS);
  localparam logic [PIX_W:0] BINS_V = (PIX_W + 1)'(BINS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  // latched word
  logic          op_q;
  logic [AW-1:0] addr_q;
  logic          in_range_q;

  logic [CNT_W-1:0]   peak_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SCALE_W-1:0] scaled_q;

  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    rd_addr;
  logic [CNT_W-1:0] rd_data;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] inc;
  logic             do_write;

  logic               div_start;
  logic               div_done;
  logic [SCALE_W-1:0] quo;

  logic           accept;
  logic [PIX_W-1:0] sel;
  logic           sel_in_range;
  logic           out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign sel          = (op == OP_READ) ? bin : pixel;
  assign sel_in_range = {1'b0, sel} < BINS_V;
  assign rd_addr      = sel[AW-1:0];

  // bin value seen in the lookup cycle; out-of-range reads as zero
  assign cur      = in_range_q ? rd_data : '0;
  assign inc      = cur + CNT_W'(1);
  assign do_write = (state == S_LOOK) && (op_q == OP_ACC) && in_range_q
                    && (cur < COUNT_LIMIT_V);

  always_comb begin
    mem_ctl.rd_en = accept && sel_in_range;
    mem_ctl.clear = accept && (op == OP_ACC) && frame_start;
    mem_ctl.wr_en = do_write;
  end

  ghist_mem #(.BINS(BINS)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (addr_q),
    .wr_data (inc),
    .rd_data (rd_data)
  );

  assign div_start = (state == S_LOOK) && (op_q == OP_READ) && (peak_q != '0);

  ghist_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (cur),
    .den    (peak_q),
    .done   (div_done),
    .quo    (quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_LOOK;
      S_LOOK: begin
        if (op_q == OP_ACC) begin
          state_next = S_IDLE;
        end else if (peak_q != '0) begin
          state_next = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV:  if (div_done) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      peak_q    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mem_ctl.clear) begin
        peak_q <= '0;
      end else if (do_write && (inc > peak_q)) begin
        peak_q <= inc;
      end
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op;
      addr_q     <= rd_addr;
      in_range_q <= sel_in_range;
    end
    if ((state == S_LOOK) && (op_q == OP_READ)) begin
      cnt_q    <= cur;
      scaled_q <= '0;
    end else if ((state == S_DIV) && div_done) begin
      scaled_q <= quo;
    end
    if ((state == S_OUT) && out_free) begin
      count  <= cnt_q;
      peak   <= peak_q;
      scaled <= scaled_q;
    end
  end

`ifndef SYNTHESIS
  a_peak_covers_write: assert property (@(posedge clk) disable iff (rst)
    do_write |=> (peak_q >= $past(inc)))
    else $error("peak below a freshly written bin count");

  a_result_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((count <= peak) && (scaled <= SCALE_W'(256))))
    else $error("result count above peak or scale out of range");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_no_write_on_clear: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.clear |-> !mem_ctl.wr_en)
    else $error("bin write coincides with frame clear");
`endif

endmodule

// File: src/ghist_mem.sv
// Bin count memory: synchronous RAM with per-entry valid bits, so a clear needs no sweep.
module ghist_mem #(
  parameter int BINS = ghist_pkg::BINS_DEF,
  localparam int AW = $clog2(BINS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ghist_pkg::mem_ctl_t        ctl,
  input  logic [AW-1:0]              rd_addr,
  input  logic [AW-1:0]              wr_addr,
  input  logic [ghist_pkg::CNT_W-1:0] wr_data,
  output logic [ghist_pkg::CNT_W-1:0] rd_data
);
  import ghist_pkg::*;

  logic [CNT_W-1:0] mem [BINS];
  logic [BINS-1:0]  valid;
  logic [CNT_W-1:0] data_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      data_q <= mem[rd_addr];
    end
  end

  // entry not valid since last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ctl.clear) begin
        valid <= '0;
      end else if (ctl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        vld_q <= valid[rd_addr] && !ctl.clear;
      end
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

// File: src/ghist_div.sv
// Restoring divider: count*256/peak, one quotient bit per cycle.
module ghist_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ghist_pkg::CNT_W-1:0]   num,
  input  logic [ghist_pkg::CNT_W-1:0]   den,
  output logic                          done,
  output logic [ghist_pkg::SCALE_W-1:0] quo
);
  import ghist_pkg::*;

  localparam int STEPS = SCALE_W;
  localparam int SW    = $clog2(STEPS + 1);

  logic [CNT_W:0]   rem;
  logic [CNT_W-1:0] den_q;
  logic [SW-1:0]    steps;
  logic             busy;
  logic             first;
  logic [CNT_W:0]   trial;
  logic             ge;

  // first step: num <= den, so top quotient bit needs no shift
  assign trial = first ? rem : {rem[CNT_W-1:0], 1'b0};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_q <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, den_q}) : trial;
      quo <= {quo[SCALE_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      first <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (steps == SW'(1));
      if (start) begin
        busy  <= 1'b1;
        first <= 1'b1;
        steps <= SW'(STEPS);
      end else if (busy) begin
        first <= 1'b0;
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// Self-checking bench for the grey histogram: per-bin counts, peak and peak-relative scale.
`timescale 1ns / 1ps

module tb_top;
  import ghist_pkg::*;

  // The predictor sizes itself from the package default the block is built with.
  // With 256 bins and 8-bit pixel/bin fields, pixels and read indices beyond
  // the bins cannot be formed, but the shadow still guards both paths.
  localparam int                BIN_COUNT    = BINS_DEF;
  localparam longint unsigned   SCALE_ONE    = 256;
  localparam int                TAIL_CYCLES  = 20;       // idle tail after the read path drains
  localparam longint unsigned   CYCLE_LIMIT  = 2000000;  // generous watchdog

  typedef struct {
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   peak;
    logic [SCALE_W-1:0] scaled;
  } bin_read_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic               op          = OP_ACC;
  logic [PIX_W-1:0]   pixel       = '0;
  logic               frame_start = 1'b0;
  logic [PIX_W-1:0]   bin         = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   peak;
  logic [SCALE_W-1:0] scaled;

  // Shadow histogram, kept in step with every accepted word.
  logic [CNT_W-1:0]   shadow_bins [0:BIN_COUNT-1];
  logic [CNT_W-1:0]   shadow_peak;
  bin_read_t          due_bin_reads [$];

  int                 mismatches  = 0;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 hold_req    = 0;   // long output hold-off, picked up by the receiver
  int                 hold_left   = 0;
  longint unsigned    cycles      = 0;

  grey_histogram_with_peak_scale dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .pixel       (pixel),
    .frame_start (frame_start),
    .bin         (bin),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .count       (count),
    .peak        (peak),
    .scaled      (scaled)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic flag_mismatch(input string field, input int unsigned got,
                               input int unsigned want);
    $display("t=%0t %s: got %0d, want %0d", $time, field, got, want);
    mismatches++;
  endtask

  // Result checker: every handshake on the output is matched to the oldest due read.
  always @(posedge clk) begin : check_results
    bin_read_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_bin_reads.size() == 0) begin
        flag_mismatch("result word with no read due", count, 0);
      end else begin
        want = due_bin_reads.pop_front();
        if (count !== want.count)   flag_mismatch("count", count, want.count);
        if (peak !== want.peak)     flag_mismatch("peak", peak, want.peak);
        if (scaled !== want.scaled) flag_mismatch("scaled", scaled, want.scaled);
      end
    end
  end

  function automatic void clear_shadow();
    foreach (shadow_bins[i]) shadow_bins[i] = '0;
    shadow_peak = '0;
  endfunction

  // Predictor: applies one accepted word to the shadow state; a read word
  // queues the result it is due to produce.
  task automatic track_histogram(input logic o, input logic [PIX_W-1:0] p,
                                 input logic fs, input logic [PIX_W-1:0] b);
    bin_read_t        r;
    logic [CNT_W-1:0] c;
    if (o == OP_ACC) begin
      if (fs) clear_shadow();
      // saturated bins ignore further hits; the peak only ever follows a real increment
      if (p < BIN_COUNT && shadow_bins[p] < COUNT_LIMIT_V) begin
        shadow_bins[p] = shadow_bins[p] + 1'b1;
        if (shadow_bins[p] > shadow_peak) shadow_peak = shadow_bins[p];
      end
    end else begin
      // frame_start is don't-care on reads
      c = (b < BIN_COUNT) ? shadow_bins[b] : '0;
      r.count  = c;
      r.peak   = shadow_peak;
      r.scaled = (shadow_peak == '0) ? '0
               : SCALE_W'((longint'(c) * SCALE_ONE) / longint'(shadow_peak));
      due_bin_reads.push_back(r);
    end
  endtask

  // Sender: optional idle gap, then hold the word until the block takes it.
  // Valid is only lowered inside a gap, so back-to-back words keep it high.
  task automatic offer_word(input logic o, input logic [PIX_W-1:0] p,
                            input logic fs, input logic [PIX_W-1:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    op          <= o;
    pixel       <= p;
    frame_start <= fs;
    bin         <= b;
    do @(posedge clk); while (!in_ready);
    track_histogram(o, p, fs, b);
  endtask

  // Drop valid, let every due read come back, then allow the pipe to empty.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (due_bin_reads.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Field extremes, both ops, empty histogram, frame clear, frame_start on a read.
  task automatic test_directed_corners();
    set_idling(0, 0);
    offer_word(OP_READ, 8'h00, 1'b0, 8'h00);   // empty: peak 0 so scaled 0
    offer_word(OP_READ, 8'hFF, 1'b1, 8'hFF);   // read ignores frame_start
    offer_word(OP_ACC,  8'h00, 1'b1, 8'hFF);
    offer_word(OP_ACC,  8'hFF, 1'b0, 8'h00);
    offer_word(OP_ACC,  8'hFF, 1'b0, 8'hAA);
    offer_word(OP_ACC,  8'hFF, 1'b0, 8'h55);
    offer_word(OP_READ, 8'h00, 1'b0, 8'hFF);   // the peak bin: scaled 256
    offer_word(OP_READ, 8'hFF, 1'b0, 8'h00);   // one third of the peak
    offer_word(OP_READ, 8'hAA, 1'b0, 8'h80);   // untouched bin
    offer_word(OP_ACC,  8'h00, 1'b0, 8'h00);
    offer_word(OP_ACC,  8'h00, 1'b0, 8'h00);
    offer_word(OP_ACC,  8'h00, 1'b0, 8'h00);   // bin 0 overtakes the peak
    offer_word(OP_READ, 8'h55, 1'b1, 8'hFF);
    offer_word(OP_READ, 8'h00, 1'b0, 8'h00);
    offer_word(OP_ACC,  8'h55, 1'b1, 8'h00);   // new frame wipes both bins and the peak
    offer_word(OP_READ, 8'h00, 1'b0, 8'h00);
    offer_word(OP_READ, 8'h00, 1'b0, 8'hFF);
    offer_word(OP_READ, 8'h00, 1'b0, 8'h55);
    offer_word(OP_ACC,  8'hAA, 1'b0, 8'h00);
    offer_word(OP_ACC,  8'hAA, 1'b1, 8'hAA);   // clear then count on the same word
    offer_word(OP_READ, 8'hFF, 1'b0, 8'hAA);
    offer_word(OP_READ, 8'h01, 1'b0, 8'h55);
    settle_block();
  endtask

  // Mostly well-formed frames: a frame-start pixel, then pixels clustered round
  // a hot grey level so peaks build up, with reads mixed in. The rest is noise:
  // stray frame starts, frames that carry on without a clear, scattered reads.
  task automatic test_random_frames(input int n_words);
    int               sent;
    int               frame_len;
    int               roll;
    logic [PIX_W-1:0] hot;
    logic             fs_bit;
    sent = 0;
    while (sent < n_words) begin
      frame_len = $urandom_range(60, 1);
      hot       = PIX_W'($urandom_range(255));
      for (int k = 0; k < frame_len && sent < n_words; k++) begin
        roll = $urandom_range(99);
        if (k == 0) begin
          fs_bit = ($urandom_range(9) != 0);
          offer_word(OP_ACC, hot, fs_bit, PIX_W'($urandom_range(255)));
        end else if (roll < 30) begin
          offer_word(OP_READ, PIX_W'($urandom_range(255)), 1'(roll % 2),
                     (roll < 20) ? hot + PIX_W'($urandom_range(3)) :
                                   PIX_W'($urandom_range(255)));
        end else begin
          fs_bit = (roll == 99);
          offer_word(OP_ACC,
                     (roll < 75) ? hot + PIX_W'($urandom_range(3)) :
                                   PIX_W'($urandom_range(255)),
                     fs_bit, PIX_W'($urandom_range(255)));
        end
        sent++;
      end
    end
    settle_block();
  endtask

  // The receiver goes quiet for a long stretch while words keep coming, so the
  // block backs up and holds in_ready low until the hold-off lapses.
  task automatic test_output_hold_off();
    set_idling(0, 0);
    hold_req = 400;
    offer_word(OP_ACC, 8'h10, 1'b1, 8'h00);
    for (int k = 0; k < 30; k++) begin
      if (k % 3 == 2)
        offer_word(OP_READ, 8'h00, 1'b0, PIX_W'(8'h10 + $urandom_range(1)));
      else
        offer_word(OP_ACC, PIX_W'(8'h10 + $urandom_range(1)), 1'b0, 8'h00);
    end
    settle_block();
  endtask

  initial begin
    clear_shadow();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    set_idling(0, 0);
    test_random_frames(380);
    set_idling(45, 0);
    test_random_frames(380);
    set_idling(0, 45);
    test_random_frames(380);
    set_idling(35, 35);
    test_random_frames(380);
    test_output_hold_off();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
